// ===== sv/psu_pkg.sv =====
// Shared constants, types and codes for the PNG scanline unfilter.
package psu_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int COL_W     = $clog2(MAX_ROW_BYTES);
  localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  localparam int ROW_BYTES_W   = 14;
  localparam int PIXEL_BYTES_W = 4;
  localparam int CNT_W = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROW_BYTES_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd1;

  // Row filter types
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // One data byte in flight between row control and reconstruction
  typedef struct packed {
    logic [7:0]           data;
    logic [7:0]           filter;
    logic [COL_W-1:0]     col;
    logic [PIX_IDX_W-1:0] left_idx;
    logic                 has_left;
    logic                 first_row;
    logic                 row_end;
  } psu_item_t;

endpackage

// ===== sv/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter: config registers, handshake and datapath wiring.
//
// Takes the inflated, filtered stream one byte per transaction and gives back
// the reconstructed image bytes (filter types None, Sub, Up, Average, Paeth).
// The first byte of each row is its filter type and yields no output
// transaction; each data byte yields exactly one. A byte with frame_start set
// begins a new image and is taken as the filter byte of its first row. Row
// length (row_bytes) and pixel size (pixel_bytes) are to be written by the user
// through the config port while the block is idle; the block does not enforce
// this. Zero acts as 1, larger values are clamped to 8192 and 8. Throughput is
// one byte per clock when the output does not stall: a byte sits in the input
// register, where the row above is read from the prior-row buffer, and is then
// reconstructed into the output register. The loop that sets this rate is the
// left-neighbour history feeding the predictor.
// A row type above 4 predicts zero and raises bad_filter on each byte of that
// row. The prior-row buffer is not cleared: it is filled by the first row of
// each image, whose above bytes read as zero.
module png_scanline_unfilter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input byte channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           frame_start_i,
  // output byte channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           row_end_o,
  output logic                           bad_filter_o,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import psu_pkg::*;

  logic [ROW_BYTES_W-1:0]   row_bytes_q;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes_q;

  logic             accept, adv, s1_valid, rd_en;
  logic [COL_W-1:0] rd_addr;
  logic [7:0]       above, res;
  psu_item_t        s1_item;

  // Config writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= ROW_BYTES_W'(1);
      pixel_bytes_q <= PIXEL_BYTES_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROW_BYTES:   row_bytes_q   <= cfg_data_i[ROW_BYTES_W-1:0];
        CFG_PIXEL_BYTES: pixel_bytes_q <= cfg_data_i[PIXEL_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input register whenever the output register is free or draining
  assign adv        = s1_valid && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  psu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .row_bytes_i   (row_bytes_q),
    .pixel_bytes_i (pixel_bytes_q),
    .adv_i         (adv),
    .s1_valid_o    (s1_valid),
    .s1_item_o     (s1_item),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  // Each result is written back as the row above for the next row
  psu_prior_ram u_prior (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (adv),
    .wr_addr_i (s1_item.col),
    .wr_data_i (res),
    .rd_data_o (above)
  );

  psu_recon u_recon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_item_i    (s1_item),
    .above_i      (above),
    .adv_i        (adv),
    .out_stall_i  (out_stall_i),
    .res_o        (res),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .row_end_o    (row_end_o),
    .bad_filter_o (bad_filter_o)
  );

endmodule

// ===== sv/psu_prior_ram.sv =====
// Prior-row byte buffer: one write and one registered read port, write-through on collision.
module psu_prior_ram (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [psu_pkg::COL_W-1:0] rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [psu_pkg::COL_W-1:0] wr_addr_i,
  input  logic [7:0]                wr_data_i,
  output logic [7:0]                rd_data_o
);
  import psu_pkg::*;

  logic [7:0] mem [MAX_ROW_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold the read data until the next read; pass the write data on a collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/psu_front.sv =====
// Row control: filter byte capture, column count and the input register.
module psu_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              frame_start_i,
  input  logic [psu_pkg::ROW_BYTES_W-1:0]   row_bytes_i,
  input  logic [psu_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_i,
  input  logic                              adv_i,
  output logic                              s1_valid_o,
  output psu_pkg::psu_item_t                s1_item_o,
  output logic                              rd_en_o,
  output logic [psu_pkg::COL_W-1:0]         rd_addr_o
);
  import psu_pkg::*;

  logic [COL_W-1:0] column_q, column_d;
  logic [7:0]       row_filter_q, row_filter_d;
  logic             awaiting_q, awaiting_d;
  logic             first_row_q, first_row_d;
  logic             s1_valid_q, s1_valid_d;
  psu_item_t        s1_item_q, s1_item_d;

  logic [CNT_W-1:0] rb_ext, rb_eff, col_next;
  logic [PIXEL_BYTES_W-1:0] bpp_eff;
  logic             is_data, row_end;

  always_comb begin
    rb_ext = CNT_W'(row_bytes_i);
    if (rb_ext == '0) begin
      rb_eff = CNT_W'(1);
    end else if (rb_ext > CNT_W'(MAX_ROW_BYTES)) begin
      rb_eff = CNT_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_ext;
    end

    if (pixel_bytes_i == '0) begin
      bpp_eff = PIXEL_BYTES_W'(1);
    end else if (pixel_bytes_i > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = pixel_bytes_i;
    end

    col_next = CNT_W'(column_q) + CNT_W'(1);
    row_end  = (col_next >= rb_eff);
    is_data  = !frame_start_i && !awaiting_q;
  end

  always_comb begin
    column_d     = column_q;
    row_filter_d = row_filter_q;
    awaiting_d   = awaiting_q;
    first_row_d  = first_row_q;
    if (accept_i) begin
      if (frame_start_i) begin
        first_row_d  = 1'b1;
        row_filter_d = data_byte_i;
        awaiting_d   = 1'b0;
        column_d     = '0;
      end else if (awaiting_q) begin
        row_filter_d = data_byte_i;
        awaiting_d   = 1'b0;
        column_d     = '0;
      end else if (row_end) begin
        column_d    = '0;
        awaiting_d  = 1'b1;
        first_row_d = 1'b0;
      end else begin
        column_d = col_next[COL_W-1:0];
      end
    end
  end

  always_comb begin
    s1_item_d.data      = data_byte_i;
    s1_item_d.filter    = row_filter_q;
    s1_item_d.col       = column_q;
    s1_item_d.left_idx  = PIX_IDX_W'(bpp_eff - PIXEL_BYTES_W'(1));
    s1_item_d.has_left  = (CNT_W'(column_q) >= CNT_W'(bpp_eff));
    s1_item_d.first_row = first_row_q;
    s1_item_d.row_end   = row_end;

    if (accept_i && is_data) begin
      s1_valid_d = 1'b1;
    end else if (adv_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      row_filter_q <= FILT_NONE;
      awaiting_q   <= 1'b1;
      first_row_q  <= 1'b1;
      s1_valid_q   <= 1'b0;
    end else begin
      column_q     <= column_d;
      row_filter_q <= row_filter_d;
      awaiting_q   <= awaiting_d;
      first_row_q  <= first_row_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && is_data) begin
      s1_item_q <= s1_item_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;
  assign rd_en_o    = accept_i && is_data;
  assign rd_addr_o  = column_q;

endmodule

// ===== sv/psu_recon.sv =====
// Byte reconstruction: neighbour histories, predictor and the result register.
module psu_recon (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psu_pkg::psu_item_t s1_item_i,
  input  logic [7:0]         above_i,
  input  logic               adv_i,
  input  logic               out_stall_i,
  output logic [7:0]         res_o,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               row_end_o,
  output logic               bad_filter_o
);
  import psu_pkg::*;

  logic [7:0] left_q   [MAX_PIXEL_BYTES];
  logic [7:0] upleft_q [MAX_PIXEL_BYTES];

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       row_end_q, bad_filter_q;

  logic [7:0] a, b, c, pred, res;
  logic       bad;
  logic [8:0] sum_ab;
  logic signed [10:0] pa, pb, pc;

  always_comb begin
    a = s1_item_i.has_left ? left_q[s1_item_i.left_idx] : 8'd0;
    b = s1_item_i.first_row ? 8'd0 : above_i;
    c = (s1_item_i.has_left && !s1_item_i.first_row) ? upleft_q[s1_item_i.left_idx] : 8'd0;

    sum_ab = {1'b0, a} + {1'b0, b};
    // Distances of a+b-c from a, b and c
    pa = $signed({3'b000, b}) - $signed({3'b000, c});
    pb = $signed({3'b000, a}) - $signed({3'b000, c});
    pc = $signed({2'b00, sum_ab}) - $signed({2'b00, c, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;

    bad = 1'b0;
    case (s1_item_i.filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: begin
        if ((pa <= pb) && (pa <= pc)) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: begin
        pred = 8'd0;
        bad  = 1'b1;
      end
    endcase
    res = s1_item_i.data + pred;
  end

  // Shift this row's results and the above-row bytes into the histories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_q[k]   <= 8'd0;
        upleft_q[k] <= 8'd0;
      end
    end else if (adv_i) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_q[k]   <= left_q[k-1];
        upleft_q[k] <= upleft_q[k-1];
      end
      left_q[0]   <= res;
      upleft_q[0] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_byte_q   <= res;
      row_end_q    <= s1_item_i.row_end;
      bad_filter_q <= bad;
    end
  end

  assign res_o        = res;
  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign row_end_o    = row_end_q;
  assign bad_filter_o = bad_filter_q;

endmodule
